@@ sv/fnu_pkg.sv @@
// Package for the face normal unit: field widths, pipeline widths, output limits
// and the side-band record that travels beside each word. No dependencies.
`default_nettype none

package fnu_pkg;

    // Port fields
    localparam int FIELD_W  = 16;
    localparam int S_DATA_W = 9 * FIELD_W;
    localparam int M_DATA_W = 3 * FIELD_W;

    // Datapath widths
    localparam int EDGE_W    = 17;  // reduced edge component, signed
    localparam int PROD_W    = 34;  // edge product, signed
    localparam int CROSS_W   = 35;  // cross component, signed
    localparam int MAG_W     = 34;  // cross magnitude
    localparam int TOP_W     = 6;   // index of the top set bit
    localparam int ALIGN_BIT = 29;
    localparam int AL_W      = ALIGN_BIT + 1;
    localparam int SQ_W      = 2 * AL_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int REM_W     = ROOT_W + 2;

    // Output saturation limits
    localparam logic [FIELD_W-1:0] OUT_MAX = 16'h7fff;
    localparam logic [FIELD_W-1:0] OUT_MIN = 16'h8000;

    // Sign bits of the cross product and the zero-vector flag
    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } item_side_t;

endpackage

`default_nettype wire

@@ sv/face_normal_unit.sv @@
// Face normal unit: edges, cross product, alignment, pipelined square root
// and three pipelined restoring dividers. Depends on fnu_pkg.
//
//  channel | ports               | contents
//  --------+---------------------+------------------------------------------
//  in      | s_tvalid/s_tready   | s_tdata: three vertices, nine 16-bit words
//  out     | m_tvalid/m_tready   | m_tdata: normal x,y,z; m_tuser: degenerate
//
// One word enters per cycle while the output is not stalled; the pipeline holds
// the 31 one-bit stages of the square root and the NORMAL_FRAC_BITS + 1
// one-bit stages of the dividers.
// Reset clears the valid bits only; the datapath holds no state between words.
// A stall at the output register freezes the whole pipeline in step.
`default_nettype none

module face_normal_unit #(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z,
    // third_x, third_y, third_z (lowest bits first)
    input  logic [fnu_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // normal_x, normal_y, normal_z (lowest bits first)
    output logic [fnu_pkg::M_DATA_W-1:0]  m_tdata,
    // degenerate
    output logic [0:0]                    m_tuser
);
    import fnu_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int F     = NORMAL_FRAC_BITS;
    localparam int QW    = F + 1;
    localparam int DIV_W = AL_W + F + 1;
    localparam int ESH   = (CW > FIELD_W) ? CW - FIELD_W : 0;
    localparam int NST   = 7 + ROOT_W + QW;

    logic                     adv;
    logic [NST-1:0]           valid_reg;
    logic                     m_valid_reg;
    logic [M_DATA_W-1:0]      m_data_reg;
    logic                     m_user_reg;

    logic signed [EDGE_W-1:0] d1_next [3];
    logic signed [EDGE_W-1:0] d2_next [3];
    logic signed [EDGE_W-1:0] d1_reg  [3];
    logic signed [EDGE_W-1:0] d2_reg  [3];
    logic signed [PROD_W-1:0] p_reg   [6];
    logic signed [CROSS_W-1:0] cross_next [3];
    logic [MAG_W-1:0]         mag_reg [3];
    logic [2:0]               neg_reg;
    logic [MAG_W-1:0]         mag4_reg [3];
    logic [TOP_W-1:0]         top_reg;
    item_side_t               side4_reg;
    logic [MAG_W-1:0]         mag_or;
    logic [TOP_W-1:0]         top_next;
    logic [AL_W-1:0]          al5_reg [3];
    item_side_t               side5_reg;
    logic [SQ_W-1:0]          sq6_reg [3];
    logic [AL_W-1:0]          al6_reg [3];
    item_side_t               side6_reg;

    // Square-root pipeline, stage 0 holds the sum of squares
    logic [SUM_W-1:0]         rt_x_reg    [ROOT_W+1];
    logic [REM_W-1:0]         rt_rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]        rt_root_reg [ROOT_W+1];
    logic [AL_W-1:0]          rt_al_reg   [ROOT_W+1][3];
    item_side_t               rt_side_reg [ROOT_W+1];

    // Divider pipeline, stage 0 is fed straight from the root
    logic [DIV_W-1:0]         dv_n_reg    [1:QW][3];
    logic [QW-1:0]            dv_q_reg    [1:QW][3];
    logic [ROOT_W-1:0]        dv_len_reg  [1:QW];
    item_side_t               dv_side_reg [1:QW];

    logic [FIELD_W-1:0]       res [3];

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Valid bits travel with the words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg   <= {valid_reg[NST-2:0], s_tvalid};
            m_valid_reg <= valid_reg[NST-1];
        end
    end

    // Stage 1: extend the vertices (sign in the narrow case, zero in the wide one), form and reduce the edges
    for (genvar i = 0; i < 3; i++) begin : g_edge
        logic [CW-1:0]     ra, rb, rc;
        logic signed [CW:0] e1, e2;
        logic [CW:0]       m1, m2, s1, s2;
        if (CW <= FIELD_W) begin : g_narrow
            assign ra = s_tdata[i*FIELD_W +: CW];
            assign rb = s_tdata[(3+i)*FIELD_W +: CW];
            assign rc = s_tdata[(6+i)*FIELD_W +: CW];
        end else begin : g_wide
            assign ra = {{(CW-FIELD_W){1'b0}}, s_tdata[i*FIELD_W +: FIELD_W]};
            assign rb = {{(CW-FIELD_W){1'b0}}, s_tdata[(3+i)*FIELD_W +: FIELD_W]};
            assign rc = {{(CW-FIELD_W){1'b0}}, s_tdata[(6+i)*FIELD_W +: FIELD_W]};
        end
        assign e1 = $signed({ra[CW-1], ra}) - $signed({rb[CW-1], rb});
        assign e2 = $signed({ra[CW-1], ra}) - $signed({rc[CW-1], rc});
        assign m1 = e1[CW] ? (CW+1)'(-e1) : (CW+1)'(e1);
        assign m2 = e2[CW] ? (CW+1)'(-e2) : (CW+1)'(e2);
        assign s1 = m1 >> ESH;
        assign s2 = m2 >> ESH;
        assign d1_next[i] = e1[CW] ? -$signed(EDGE_W'(s1)) : $signed(EDGE_W'(s1));
        assign d2_next[i] = e2[CW] ? -$signed(EDGE_W'(s2)) : $signed(EDGE_W'(s2));
    end

    // Stage 3 helper: cross components from the registered products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cross_next[i] = CROSS_W'(p_reg[2*i]) - CROSS_W'(p_reg[2*i+1]);
        end
    end

    // Stage 4 helpers: top set bit over the three magnitudes
    always_comb begin
        mag_or   = mag_reg[0] | mag_reg[1] | mag_reg[2];
        top_next = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (mag_or[b]) top_next = TOP_W'(b);
        end
    end

    // Stages 1 to 7: edges, products, cross, top bit, align, squares, sum
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                d1_reg[i] <= d1_next[i];
                d2_reg[i] <= d2_next[i];
            end
            p_reg[0] <= PROD_W'(d1_reg[1] * d2_reg[2]);
            p_reg[1] <= PROD_W'(d2_reg[1] * d1_reg[2]);
            p_reg[2] <= PROD_W'(d2_reg[0] * d1_reg[2]);
            p_reg[3] <= PROD_W'(d1_reg[0] * d2_reg[2]);
            p_reg[4] <= PROD_W'(d1_reg[0] * d2_reg[1]);
            p_reg[5] <= PROD_W'(d1_reg[1] * d2_reg[0]);
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= cross_next[i][CROSS_W-1] ? MAG_W'(-cross_next[i])
                                                       : MAG_W'(cross_next[i]);
                neg_reg[i] <= cross_next[i][CROSS_W-1];
            end
            mag4_reg        <= mag_reg;
            top_reg         <= top_next;
            side4_reg.neg   <= neg_reg;
            side4_reg.degen <= (mag_or == '0);
            for (int i = 0; i < 3; i++) begin
                if (top_reg < TOP_W'(ALIGN_BIT))
                    al5_reg[i] <= AL_W'(mag4_reg[i] << (TOP_W'(ALIGN_BIT) - top_reg));
                else
                    al5_reg[i] <= AL_W'(mag4_reg[i] >> (top_reg - TOP_W'(ALIGN_BIT)));
            end
            side5_reg <= side4_reg;
            for (int i = 0; i < 3; i++) begin
                sq6_reg[i] <= al5_reg[i] * al5_reg[i];
            end
            al6_reg   <= al5_reg;
            side6_reg <= side5_reg;
            rt_x_reg[0]    <= SUM_W'(sq6_reg[0]) + SUM_W'(sq6_reg[1]) + SUM_W'(sq6_reg[2]);
            rt_rem_reg[0]  <= '0;
            rt_root_reg[0] <= '0;
            rt_al_reg[0]   <= al6_reg;
            rt_side_reg[0] <= side6_reg;
        end
    end

    // Square root: one result bit per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        logic [REM_W-1:0] rem2, trial;
        logic             ge;
        assign rem2  = {rt_rem_reg[k][REM_W-3:0], rt_x_reg[k][SUM_W-1 -: 2]};
        assign trial = {rt_root_reg[k], 2'b01};
        assign ge    = rem2 >= trial;
        always_ff @(posedge aclk) begin
            if (adv) begin
                rt_x_reg[k+1]    <= rt_x_reg[k] << 2;
                rt_rem_reg[k+1]  <= ge ? rem2 - trial : rem2;
                rt_root_reg[k+1] <= {rt_root_reg[k][ROOT_W-2:0], ge};
                rt_al_reg[k+1]   <= rt_al_reg[k];
                rt_side_reg[k+1] <= rt_side_reg[k];
            end
        end
    end

    // Dividers: one quotient bit per stage, rounded by adding half the length
    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [DIV_W-1:0]  n_in [3];
        logic [QW-1:0]     q_in [3];
        logic [ROOT_W-1:0] len_in;
        item_side_t        side_in;
        logic [DIV_W-1:0]  dsh;
        if (j == 0) begin : g_first
            assign len_in  = rt_root_reg[ROOT_W];
            assign side_in = rt_side_reg[ROOT_W];
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign n_in[i] = (DIV_W'(rt_al_reg[ROOT_W][i]) << F)
                               + DIV_W'(rt_root_reg[ROOT_W] >> 1);
                assign q_in[i] = '0;
            end
        end else begin : g_next
            assign len_in  = dv_len_reg[j];
            assign side_in = dv_side_reg[j];
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign n_in[i] = dv_n_reg[j][i];
                assign q_in[i] = dv_q_reg[j][i];
            end
        end
        assign dsh = DIV_W'(len_in) << (F - j);
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int i = 0; i < 3; i++) begin
                    if (n_in[i] >= dsh) begin
                        dv_n_reg[j+1][i] <= n_in[i] - dsh;
                        dv_q_reg[j+1][i] <= {q_in[i][QW-2:0], 1'b1};
                    end else begin
                        dv_n_reg[j+1][i] <= n_in[i];
                        dv_q_reg[j+1][i] <= {q_in[i][QW-2:0], 1'b0};
                    end
                end
                dv_len_reg[j+1]  <= len_in;
                dv_side_reg[j+1] <= side_in;
            end
        end
    end

    // Apply sign, saturate, zero the degenerate case
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [31:0] qz;
            qz = 32'(dv_q_reg[QW][i]);
            if (dv_side_reg[QW].degen)
                res[i] = '0;
            else if (!dv_side_reg[QW].neg[i])
                res[i] = (qz > 32'(OUT_MAX)) ? OUT_MAX : qz[FIELD_W-1:0];
            else
                res[i] = (qz > 32'(OUT_MIN)) ? OUT_MIN : FIELD_W'(32'd0 - qz);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {res[2], res[1], res[0]};
            m_user_reg <= dv_side_reg[QW].degen;
        end
    end

endmodule

`default_nettype wire

@@ sv/fnu_checker.sv @@
// Port-level checks for the face normal unit, bound to the top level.
// Depends on fnu_pkg for the port widths.
`default_nettype none

module fnu_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fnu_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [0:0]                    m_tuser
);
    import fnu_pkg::*;

    // Held result word stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    // A stalled output stalls the input side
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline frozen");

    // Degenerate faces give a zero normal
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("degenerate word with non-zero normal");

    // A unit normal is never all zero
    a_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata != '0)
        else $error("zero normal without degenerate flag");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word after reset");

endmodule

bind face_normal_unit fnu_checker u_fnu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking bench for the face normal unit: drives vertex triples, predicts
// each unit normal and compares it with every output word. Depends on fnu_pkg.
`timescale 1ns / 100ps

module testbench;
    import fnu_pkg::*;

    localparam int CW = 16;
    localparam int FB = 14;
    localparam int N_RANDOM = 1530;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic        degen;
    } normal_t;

    typedef struct {
        logic [S_DATA_W-1:0] face;
        logic                fixed;
        normal_t             want;
    } face_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;

    normal_t   normals_due[$];
    face_row_t face_table[$];
    int        n_fail = 0;
    int        n_seen = 0;
    int        n_degen_seen = 0;
    int        idle_cnt = 0;
    logic      calm = 1'b0;

    face_normal_unit #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // Integer square root, bit by bit
    function automatic logic [63:0] isqrt64(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Predict the unit normal of one face word
    function automatic normal_t face_normal(logic [S_DATA_W-1:0] face);
        longint  v[9];
        longint  e1[3], e2[3], cr[3];
        logic [63:0] mg[3];
        logic [63:0] mx, sum, len, q;
        longint  sq;
        int      top;
        normal_t r;
        for (int i = 0; i < 9; i++)
            v[i] = longint'($signed(face[16*i +: 16]));
        for (int i = 0; i < 3; i++) begin
            e1[i] = v[i] - v[3+i];
            e2[i] = v[i] - v[6+i];
        end
        cr[0] = e1[1]*e2[2] - e2[1]*e1[2];
        cr[1] = e2[0]*e1[2] - e1[0]*e2[2];
        cr[2] = e1[0]*e2[1] - e1[1]*e2[0];
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = cr[i] < 0 ? -cr[i] : cr[i];
            if (mg[i] > mx) mx = mg[i];
        end
        r = '0;
        if (mx == 0) begin
            r.degen = 1'b1;
            return r;
        end
        top = 0;
        while (top < 63 && (mx >> (top + 1)) != 0) top++;
        for (int i = 0; i < 3; i++)
            mg[i] = top < ALIGN_BIT ? mg[i] << (ALIGN_BIT - top) : mg[i] >> (top - ALIGN_BIT);
        sum = mg[0]*mg[0] + mg[1]*mg[1] + mg[2]*mg[2];
        len = isqrt64(sum);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            q = ((mg[i] << FB) + (len >> 1)) / len;
            sq = cr[i] < 0 ? -longint'(q) : longint'(q);
            if (sq > 32767) sq = 32767;
            if (sq < -32768) sq = -32768;
            if (i == 0) r.nx = sq[15:0];
            else if (i == 1) r.ny = sq[15:0];
            else r.nz = sq[15:0];
        end
        return r;
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_face(int c[9]);
        logic [S_DATA_W-1:0] f;
        for (int i = 0; i < 9; i++) f[16*i +: 16] = c[i][15:0];
        return f;
    endfunction

    function automatic normal_t known(int x, int y, int z, logic d);
        normal_t r;
        r.nx = x[15:0];
        r.ny = y[15:0];
        r.nz = z[15:0];
        r.degen = d;
        return r;
    endfunction

    task automatic add_row(int c[9], logic fx, normal_t w);
        face_row_t row;
        row.face = pack_face(c);
        row.fixed = fx;
        row.want = fx ? w : face_normal(row.face);
        face_table.push_back(row);
    endtask

    // Random face: small shapes near a random origin, full-range vertices or extreme corners
    function automatic logic [S_DATA_W-1:0] random_face();
        logic [S_DATA_W-1:0] f;
        logic [15:0]         org [3];
        int                  k;
        k = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++) org[a] = 16'($urandom);
        for (int i = 0; i < 9; i++) begin
            if (k < 4) f[16*i +: 16] = 16'($urandom);
            else if (k < 8)
                f[16*i +: 16] = org[i % 3] + 16'($urandom_range(0, 255)) - 16'd128;
            else
                f[16*i +: 16] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        end
        // Occasionally collapse the face
        if ($urandom_range(0, 19) == 0) f[16*3 +: 48] = f[0 +: 48];
        return f;
    endfunction

    // Sink side: random stalls, checking each accepted word
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                normal_t got, w;
                got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser[0]};
                n_seen++;
                if (got.degen) n_degen_seen++;
                if (normals_due.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got);
                    n_fail++;
                end else begin
                    w = normals_due.pop_front();
                    if (got !== w) begin
                        $display({"%0t: mismatch expected x=%h y=%h z=%h d=%b",
                                  " actual x=%h y=%h z=%h d=%b"},
                                 $time, w.nx, w.ny, w.nz, w.degen,
                                 got.nx, got.ny, got.nz, got.degen);
                        n_fail++;
                    end
                end
            end
            m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 31);
        end
    end

    // Watchdog on accepted words
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one face word, holding it until taken
    task automatic send_face(logic [S_DATA_W-1:0] f, normal_t w);
        while (!calm && $urandom_range(0, 99) < 31) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= f;
        normals_due.push_back(w);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        int z[9], c[9];
        logic [S_DATA_W-1:0] f;
        z = '{default: 0};
        // Directed faces
        add_row(z, 1'b1, known(0, 0, 0, 1'b1));
        c = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
        add_row(c, 1'b1, known(0, 0, 16384, 1'b0));
        c = '{0, 0, 0, 0, 256, 0, 256, 0, 0};
        add_row(c, 1'b1, known(0, 0, -16384, 1'b0));
        c = '{0, 0, 0, 0, 256, 0, 0, 0, 256};
        add_row(c, 1'b1, known(16384, 0, 0, 1'b0));
        c = '{0, 0, 0, 0, 0, 256, 256, 0, 0};
        add_row(c, 1'b1, known(0, 16384, 0, 1'b0));
        c = '{0, 0, 0, 100, 100, 100, 300, 300, 300};
        add_row(c, 1'b1, known(0, 0, 0, 1'b1));
        c = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        add_row(c, 1'b1, known(0, 0, 0, 1'b1));
        c = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
        add_row(c, 1'b0, '0);
        c = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
        add_row(c, 1'b0, '0);
        c = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768};
        add_row(c, 1'b0, '0);
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        add_row(c, 1'b0, '0);
        c = '{0, 0, 0, 1, 1, 0, 0, 1, 1};
        add_row(c, 1'b0, '0);
        c = '{-1, -1, -1, 0, 0, 0, 5, -3, 7};
        add_row(c, 1'b0, '0);
        c = '{-21846, 21845, -21846, 21845, -21846, 21845, 1, -1, 2};
        add_row(c, 1'b0, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (face_table[i]) send_face(face_table[i].face, face_table[i].want);
        // Random faces, with a calm stretch in the middle
        for (int i = 0; i < N_RANDOM; i++) begin
            calm <= (i >= 600 && i < 800);
            f = random_face();
            send_face(f, face_normal(f));
        end
        s_tvalid <= 1'b0;
        while (normals_due.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);

        $display("Ran %0d faces, %0d normals checked, %0d degenerate.",
                 face_table.size() + N_RANDOM, n_seen, n_degen_seen);
        if (n_fail == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule

@@ face_normal_unit.f @@
sv/fnu_pkg.sv
sv/face_normal_unit.sv
sv/fnu_checker.sv
tb/testbench.sv
